FILE: rtl/core/gregorian_date_arithmetic_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the date arithmetic block
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH

`ifndef SYNTHESIS
`define GDA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GDA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define GDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Word types, op codes, command and status types and calendar tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

  localparam int SER_W = 23;
  localparam logic [SER_W-1:0] MAX_SER = 23'd3652059;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_SUB     = 3'd1;
  localparam logic [2:0] OP_UNTIL   = 3'd2;
  localparam logic [2:0] OP_EARLIER = 3'd3;
  localparam logic [2:0] OP_XMAS    = 3'd4;
  localparam logic [2:0] OP_LEAP    = 3'd5;

  localparam logic [SER_W-1:0] DAYS_400 = 23'd146097;
  localparam logic [SER_W-1:0] DAYS_100 = 23'd36524;
  localparam logic [SER_W-1:0] DAYS_4   = 23'd1461;
  localparam logic [SER_W-1:0] DAYS_1   = 23'd365;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] amount;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;
  } gda_in_t;

  typedef struct packed {
    logic [4:0]  res_day;
    logic [3:0]  res_month;
    logic [13:0] res_year;
    logic [21:0] day_count;
    logic        is_earlier;
    logic        is_leap;
    logic        error;
  } gda_out_t;

  typedef enum logic [1:0] {
    SEL_BASE,
    SEL_OTHER,
    SEL_XMAS
  } date_sel_t;

  typedef enum logic [2:0] {
    PH_400,
    PH_100,
    PH_4,
    PH_1,
    PH_MON
  } phase_t;

  typedef struct packed {
    logic      load;
    logic      ser_s1;
    logic      ser_s2;
    date_sel_t sel;
    logic      store_a;
    logic      add;
    logic      sub;
    logic      cmp;
    logic      set_err;
    logic      step;
    phase_t    phase;
    logic      yfin;
    logic      emit;
  } gda_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ok;
    logic       add_bad;
    logic       sub_bad;
    logic       cmp_bad;
    logic       ge;
    logic       lim;
    logic       out_free;
  } gda_status_t;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic lp);
    logic [4:0] r;
    case (m) inside
      4'd2:                                  r = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:               r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      default:                               r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gda_datapath.sv
// ----------------------------------------------------------------------------
// gda_datapath
// Day-number unit, range checks, year/month stepping unit, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_arithmetic_assert.svh"

module gda_datapath
  import gda_pkg::*;
#(
  parameter int COUNT_WIDTH = 22
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire gda_in_t     in_word,
  input  wire gda_cmd_t    cmd,
  output gda_status_t      status,
  input  wire logic        out_stall,
  output logic             out_valid,
  output gda_out_t         out_word
);

  gda_in_t          inp;
  logic [SER_W-1:0] a, n, ser;
  logic             ser_ok, ser_lp, base_lp;
  logic [13:0]      yy;
  logic [3:0]       mm;
  logic [1:0]       q100, q1;
  logic [4:0]       q4;
  logic             leapy, err, early;
  logic [21:0]      cnt;

  logic [4:0]       s_d;
  logic [3:0]       s_m;
  logic [13:0]      s_y;
  logic [21:0]      s_p365;
  logic [6:0]       s_q100;
  logic [4:0]       s_q400;

  logic [4:0]       d_sel;
  logic [3:0]       m_sel;
  logic [13:0]      y_sel, y_dec;

  logic             c100, c400, lp2;
  logic [6:0]       q100p;
  logic [4:0]       q400p;
  logic [13:0]      p;
  logic [SER_W-1:0] ser_next;
  logic             ok_next;

  logic [SER_W-1:0] sum, diff, kstep;
  logic             amt_big;
  gda_out_t         res;

  always_comb begin
    case (cmd.sel)
      SEL_OTHER: begin
        d_sel = inp.other_day;
        m_sel = inp.other_month;
        y_sel = inp.other_year;
      end
      SEL_XMAS: begin
        d_sel = 5'd25;
        m_sel = 4'd12;
        y_sel = (inp.month == 4'd12 && inp.day > 5'd25) ? inp.year + 14'd1 : inp.year;
      end
      default: begin
        d_sel = inp.day;
        m_sel = inp.month;
        y_sel = inp.year;
      end
    endcase
    y_dec = y_sel - 14'd1;
  end

  always_comb begin
    c100     = (14'(s_q100) * 14'd100) == s_y;
    c400     = (14'(s_q400) * 14'd400) == s_y;
    q100p    = s_q100 - 7'(c100);
    q400p    = s_q400 - 5'(c400);
    lp2      = (s_y[1:0] == 2'b00) && (!c100 || c400);
    p        = s_y - 14'd1;
    ser_next = SER_W'(s_p365) + SER_W'(p >> 2) - SER_W'(q100p) + SER_W'(q400p)
             + SER_W'(cum_days(s_m)) + SER_W'(lp2 && s_m > 4'd2) + SER_W'(s_d);
    ok_next  = s_y >= 14'd1 && s_y <= 14'd9999 && s_m >= 4'd1 && s_m <= 4'd12
             && s_d >= 5'd1 && s_d <= days_in(s_m, lp2);
  end

  always_comb begin
    amt_big = (inp.amount >> COUNT_WIDTH) != '0;
    sum     = a + SER_W'(inp.amount);
    diff    = ser - a;
    case (cmd.phase)
      PH_400:  kstep = DAYS_400;
      PH_100:  kstep = DAYS_100;
      PH_4:    kstep = DAYS_4;
      PH_1:    kstep = DAYS_1;
      default: kstep = SER_W'(days_in(mm, leapy));
    endcase
    status.op       = inp.op;
    status.ok       = ser_ok;
    status.add_bad  = amt_big || sum > MAX_SER;
    status.sub_bad  = amt_big || SER_W'(inp.amount) >= a;
    status.cmp_bad  = ser < a || (diff >> COUNT_WIDTH) != '0;
    status.ge       = n >= kstep;
    case (cmd.phase)
      PH_100:  status.lim = q100 == 2'd3;
      PH_1:    status.lim = q1 == 2'd3;
      PH_MON:  status.lim = mm == 4'd12;
      default: status.lim = 1'b0;
    endcase
    status.out_free = !out_valid || !out_stall;
  end

  always_comb begin
    res = '0;
    if (!err) begin
      case (inp.op)
        OP_ADD, OP_SUB: begin
          res.res_day   = 5'(n) + 5'd1;
          res.res_month = mm;
          res.res_year  = yy;
        end
        OP_UNTIL, OP_XMAS: res.day_count = cnt;
        OP_EARLIER:        res.is_earlier = early;
        OP_LEAP:           res.is_leap = base_lp;
        default:           res = '0;
      endcase
    end
    res.error = err;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inp   <= in_word;
      err   <= 1'b0;
      early <= 1'b0;
      cnt   <= '0;
    end
    if (cmd.ser_s1) begin
      s_d    <= d_sel;
      s_m    <= m_sel;
      s_y    <= y_sel;
      s_p365 <= 22'(22'(y_dec) * 22'd365);
      s_q100 <= 7'((27'(y_sel) * 27'd5243) >> 19);
      s_q400 <= 5'((16'(y_sel >> 4) * 16'd41) >> 10);
    end
    if (cmd.ser_s2) begin
      ser    <= ser_next;
      ser_ok <= ok_next;
      ser_lp <= lp2;
    end
    if (cmd.store_a) begin
      a       <= ser;
      base_lp <= ser_lp;
    end
    if (cmd.add || cmd.sub) begin
      n    <= (cmd.add ? sum : a - SER_W'(inp.amount)) - SER_W'(1);
      yy   <= '0;
      mm   <= 4'd1;
      q100 <= '0;
      q4   <= '0;
      q1   <= '0;
    end
    if (cmd.cmp) begin
      cnt   <= diff[21:0];
      early <= a < ser;
    end
    if (cmd.set_err) begin
      err <= 1'b1;
    end
    if (cmd.step) begin
      n <= n - kstep;
      case (cmd.phase)
        PH_400: yy <= yy + 14'd400;
        PH_100: begin
          yy   <= yy + 14'd100;
          q100 <= q100 + 2'd1;
        end
        PH_4: begin
          yy <= yy + 14'd4;
          q4 <= q4 + 5'd1;
        end
        PH_1: begin
          yy <= yy + 14'd1;
          q1 <= q1 + 2'd1;
        end
        default: mm <= mm + 4'd1;
      endcase
    end
    if (cmd.yfin) begin
      yy    <= yy + 14'd1;
      leapy <= (q1 == 2'd3) && (q4 != 5'd24 || q100 == 2'd3);
    end
    if (cmd.emit) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `GDA_ASSERT_IMPLY(a_emit_free, clk, rst, cmd.emit, status.out_free, "emit into a held word")
  `GDA_ASSERT_IMPLY(a_err_zero, clk, rst, out_valid && out_word.error, out_word.day_count == '0 && out_word.res_year == '0 && out_word.is_leap == 1'b0, "error word not cleared")
  `GDA_ASSERT_IMPLY(a_mon_range, clk, rst, cmd.step && cmd.phase == PH_MON, mm < 4'd12, "month step past December")

endmodule

`default_nettype wire

FILE: rtl/core/gda_ctrl.sv
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer: date conversion, checks, year and month stepping, result emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_arithmetic_assert.svh"

module gda_ctrl
  import gda_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire gda_status_t status,
  output gda_cmd_t         cmd
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_BA1  = 19'h00002,
    S_BA2  = 19'h00004,
    S_BCHK = 19'h00008,
    S_ADD  = 19'h00010,
    S_SUB  = 19'h00020,
    S_OT1  = 19'h00040,
    S_OT2  = 19'h00080,
    S_OCHK = 19'h00100,
    S_XM1  = 19'h00200,
    S_XM2  = 19'h00400,
    S_CMP  = 19'h00800,
    S_Y400 = 19'h01000,
    S_Y100 = 19'h02000,
    S_Y4   = 19'h04000,
    S_Y1   = 19'h08000,
    S_YFIN = 19'h10000,
    S_MON  = 19'h20000,
    S_FIN  = 19'h40000
  } state_t;

  state_t state, state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_BASE;
    cmd.phase  = PH_400;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_BA1;
        end
      end
      S_BA1: begin
        cmd.ser_s1 = 1'b1;
        state_next = S_BA2;
      end
      S_BA2: begin
        cmd.ser_s2 = 1'b1;
        state_next = S_BCHK;
      end
      S_BCHK: begin
        cmd.store_a = 1'b1;
        if (!status.ok) begin
          cmd.set_err = 1'b1;
          state_next  = S_FIN;
        end else begin
          case (status.op)
            OP_ADD:             state_next = S_ADD;
            OP_SUB:             state_next = S_SUB;
            OP_UNTIL, OP_EARLIER: state_next = S_OT1;
            OP_XMAS:            state_next = S_XM1;
            OP_LEAP:            state_next = S_FIN;
            default: begin
              cmd.set_err = 1'b1;
              state_next  = S_FIN;
            end
          endcase
        end
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (status.add_bad) begin
          cmd.set_err = 1'b1;
          state_next  = S_FIN;
        end else begin
          state_next = S_Y400;
        end
      end
      S_SUB: begin
        cmd.sub = 1'b1;
        if (status.sub_bad) begin
          cmd.set_err = 1'b1;
          state_next  = S_FIN;
        end else begin
          state_next = S_Y400;
        end
      end
      S_OT1: begin
        cmd.sel    = SEL_OTHER;
        cmd.ser_s1 = 1'b1;
        state_next = S_OT2;
      end
      S_OT2: begin
        cmd.ser_s2 = 1'b1;
        state_next = S_OCHK;
      end
      S_OCHK: begin
        if (!status.ok) begin
          cmd.set_err = 1'b1;
          state_next  = S_FIN;
        end else begin
          state_next = S_CMP;
        end
      end
      S_XM1: begin
        cmd.sel    = SEL_XMAS;
        cmd.ser_s1 = 1'b1;
        state_next = S_XM2;
      end
      S_XM2: begin
        cmd.ser_s2 = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if ((status.op == OP_UNTIL || status.op == OP_XMAS) && status.cmp_bad) begin
          cmd.set_err = 1'b1;
        end
        state_next = S_FIN;
      end
      S_Y400: begin
        cmd.phase = PH_400;
        if (status.ge) cmd.step = 1'b1;
        else state_next = S_Y100;
      end
      S_Y100: begin
        cmd.phase = PH_100;
        if (status.ge && !status.lim) cmd.step = 1'b1;
        else state_next = S_Y4;
      end
      S_Y4: begin
        cmd.phase = PH_4;
        if (status.ge) cmd.step = 1'b1;
        else state_next = S_Y1;
      end
      S_Y1: begin
        cmd.phase = PH_1;
        if (status.ge && !status.lim) cmd.step = 1'b1;
        else state_next = S_YFIN;
      end
      S_YFIN: begin
        cmd.yfin   = 1'b1;
        state_next = S_MON;
      end
      S_MON: begin
        cmd.phase = PH_MON;
        if (status.ge && !status.lim) cmd.step = 1'b1;
        else state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `GDA_ASSERT_NEXT(a_accept, clk, rst, in_valid && !in_stall, state == S_BA1, "accept did not start conversion")
  `GDA_ASSERT_IMPLY(a_step_phase, clk, rst, cmd.step, state == S_Y400 || state == S_Y100 || state == S_Y4 || state == S_Y1 || state == S_MON, "step outside stepping states")
  `GDA_ASSERT_IMPLY(a_emit_fin, clk, rst, cmd.emit, state == S_FIN, "emit outside final state")

endmodule

`default_nettype wire

FILE: rtl/core/gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// Gregorian date add/subtract, day count, compare, days to Dec 25, leap year.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_word carries one request word; it is
// taken when in_valid is high and in_stall low. Output channel
// out_valid/out_stall/out_word returns exactly one result word per request.
// One request is worked at a time. Add and subtract run through the shared
// subtract unit that peels off 400-, 100-, 4- and 1-year blocks and then
// months, one block or month per cycle.
// The next request is taken the cycle after the result is written, once
// the sequencer is back in idle. While the output word waits under
// out_stall the sequencer holds the finished result until the output
// register frees; such stalls delay the result and the next request.
// Reset (rst, synchronous) empties the output register and returns the
// sequencer to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_arithmetic
  import gda_pkg::*;
#(
  parameter int COUNT_WIDTH = 22
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire gda_in_t  in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output gda_out_t      out_word
);

  gda_cmd_t    cmd;
  gda_status_t status;

  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gda_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
